### hdl/alba_pkg.sv
// Package for the ambient light brightness averager.
// Holds the widths, window constants, register indexes and control structs.
// Depends on nothing; every other file imports it.
`default_nettype none
package alba_pkg;

	localparam int unsigned SAMPLE_W   = 10;
	localparam int unsigned LEVEL_W    = 8;
	localparam int unsigned WIN_LOG2   = 4;
	localparam int unsigned WINDOW_LEN = 1 << WIN_LOG2;
	localparam int unsigned TOTAL_W    = SAMPLE_W + WIN_LOG2;
	localparam int unsigned PROD_W     = LEVEL_W + SAMPLE_W;
	localparam int unsigned FULL_SCALE = 1023;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = LEVEL_W;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BRIGHT = 1'd1;

	localparam logic [LEVEL_W-1:0] MAX_BRIGHT_RST = 8'd255;
	localparam logic [LEVEL_W-1:0] MIN_BRIGHT_RST = 8'd10;

	typedef logic [SAMPLE_W-1:0]   sample_t;
	typedef logic [LEVEL_W-1:0]    level_t;
	typedef logic [TOTAL_W-1:0]    total_t;
	typedef logic [PROD_W-1:0]     prod_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	typedef struct packed {
		logic seed;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic en_s2;
		logic en_out;
	} scale_ctl_t;

endpackage
`default_nettype wire

### hdl/ambient_light_brightness_average_core.sv
// Top level of the ambient light brightness averager: window cell chain,
// running sum, configuration registers and handshake control.
// Depends on alba_pkg, alba_cell and alba_scale.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    action, light_sample
//   out      source     out_valid / out_stall  brightness
//   cfg      sink       cfg_write              cfg_index, cfg_data
//
// One request is accepted per cycle while in_stall is low.
// The window cells and running sum update in the accept cycle; the multiplier
// and the divide-and-clamp stage each take one further pipeline register.
// Reset clears the sum, seeded flag and valid bits; the cells need no reset.
// A stalled output holds the pipeline; empty stages still fill behind it.
`default_nettype none
module ambient_light_brightness_average_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire                   action,
	input  alba_pkg::sample_t     light_sample,
	output logic                  out_valid,
	input  wire                   out_stall,
	output alba_pkg::level_t      brightness,
	input  wire                   cfg_write,
	input  alba_pkg::cfg_idx_t    cfg_index,
	input  alba_pkg::cfg_data_t   cfg_data
);
	import alba_pkg::*;

	level_t     max_bright_q;
	level_t     min_bright_q;
	total_t     total_q;
	logic       seeded_q;
	logic       v1_q;
	logic       v2_q;
	logic       out_valid_q;
	sample_t    avg_s1;

	logic       adv_out;
	logic       adv2;
	logic       adv1;
	logic       accept;
	logic       push;
	cell_ctl_t  cell_ctl;
	scale_ctl_t scale_ctl;
	total_t     total_next;
	sample_t    entries [WINDOW_LEN];

	assign adv_out = !out_valid_q || !out_stall;
	assign adv2    = !v2_q || adv_out;
	assign adv1    = !v1_q || adv2;
	assign accept  = in_valid && adv1;
	assign push    = accept && action;

	assign cell_ctl.seed  = push && !seeded_q;
	assign cell_ctl.shift = push && seeded_q;

	assign scale_ctl.en_s2  = adv2 && v1_q;
	assign scale_ctl.en_out = adv_out && v2_q;

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_LEN; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				alba_cell u_cell (
					.clk   (clk),
					.ctl   (cell_ctl),
					.seed  (light_sample),
					.prev  (light_sample),
					.entry (entries[gi])
				);
			end else begin : g_body
				alba_cell u_cell (
					.clk   (clk),
					.ctl   (cell_ctl),
					.seed  (light_sample),
					.prev  (entries[gi-1]),
					.entry (entries[gi])
				);
			end
		end
	endgenerate

	always_comb begin
		total_next = total_q;
		if (cell_ctl.seed) begin
			total_next = {light_sample, WIN_LOG2'(0)};
		end else if (cell_ctl.shift) begin
			total_next = total_q - TOTAL_W'(entries[WINDOW_LEN-1]) + TOTAL_W'(light_sample);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bright_q <= MAX_BRIGHT_RST;
			min_bright_q <= MIN_BRIGHT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MAX_BRIGHT: max_bright_q <= cfg_data;
				REG_MIN_BRIGHT: min_bright_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			seeded_q    <= 1'b0;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			total_q <= total_next;
			if (push) begin
				seeded_q <= 1'b1;
			end
			if (adv1) begin
				v1_q <= in_valid;
			end
			if (adv2) begin
				v2_q <= v1_q;
			end
			if (adv_out) begin
				out_valid_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			avg_s1 <= total_next[TOTAL_W-1 -: SAMPLE_W];
		end
	end

	alba_scale u_scale (
		.clk            (clk),
		.ctl            (scale_ctl),
		.avg_s1         (avg_s1),
		.max_brightness (max_bright_q),
		.min_brightness (min_bright_q),
		.brightness     (brightness)
	);

	assign in_stall  = !adv1;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### hdl/alba_cell.sv
// One window cell: holds one light reading of the moving-average window.
// Loads the seed reading or takes its neighbor's entry on a push.
// Depends on alba_pkg.
`default_nettype none
module alba_cell (
	input  wire                  clk,
	input  alba_pkg::cell_ctl_t  ctl,
	input  alba_pkg::sample_t    seed,
	input  alba_pkg::sample_t    prev,
	output alba_pkg::sample_t    entry
);
	import alba_pkg::*;

	sample_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.seed) begin
			entry_q <= seed;
		end else if (ctl.shift) begin
			entry_q <= prev;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

### hdl/alba_scale.sv
// Scaling pipeline: multiplies the window average by max_brightness,
// divides by full scale exactly and clamps up to min_brightness.
// Depends on alba_pkg.
`default_nettype none
module alba_scale (
	input  wire                   clk,
	input  alba_pkg::scale_ctl_t  ctl,
	input  alba_pkg::sample_t     avg_s1,
	input  alba_pkg::level_t      max_brightness,
	input  alba_pkg::level_t      min_brightness,
	output alba_pkg::level_t      brightness
);
	import alba_pkg::*;

	prod_t                 prod_s2;
	level_t                level_s3;
	level_t                quot0;
	logic [SAMPLE_W:0]     rem;
	level_t                quot;

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			prod_s2 <= PROD_W'(max_brightness) * PROD_W'(avg_s1);
		end
	end

	// Division by 2^10 - 1: x = 1024*q0 + low, so the remainder against 1023
	// is low + q0, which stays below twice the divisor.
	always_comb begin
		quot0 = prod_s2[PROD_W-1:SAMPLE_W];
		rem   = {1'b0, prod_s2[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(quot0);
		quot  = (rem >= (SAMPLE_W+1)'(FULL_SCALE)) ? quot0 + 8'd1 : quot0;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_out) begin
			level_s3 <= (quot < min_brightness) ? min_brightness : quot;
		end
	end

	assign brightness = level_s3;

endmodule
`default_nettype wire

### verif/tb_ambient_light_brightness_average_core.sv
// Self-checking testbench for ambient_light_brightness_average_core.
// A clocked driver and monitor run the request and result channels under random
// idling. Expected brightness comes from a local window model. Depends on alba_pkg.
`default_nettype none
module tb_ambient_light_brightness_average_core;
	import alba_pkg::*;

	localparam logic ACT_QUERY = 1'b0;
	localparam logic ACT_PUSH = 1'b1;
	localparam int NUM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct {
		logic act;
		sample_t smp;
	} light_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ACT_QUERY;
	sample_t light_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	level_t brightness;
	logic cfg_write = 1'b0;
	cfg_idx_t cfg_index = REG_MAX_BRIGHT;
	cfg_data_t cfg_data = '0;

	light_req_t pending_reqs[$];
	level_t expected_levels[$];

	sample_t window_ring[WINDOW_LEN];
	total_t ring_sum = '0;
	logic [WIN_LOG2-1:0] oldest_slot = '0;
	bit ring_seeded = 1'b0;
	level_t max_level = MAX_BRIGHT_RST;
	level_t min_level = MIN_BRIGHT_RST;

	int gap_pct = 0;
	int stall_pct = 0;
	int send_gap = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int error_count = 0;

	ambient_light_brightness_average_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.light_sample(light_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.brightness(brightness),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	task automatic apply_light_request(input logic act, input sample_t smp);
		int unsigned avg;
		int unsigned lvl;
		if (act == ACT_PUSH) begin
			if (!ring_seeded) begin
				foreach (window_ring[i])
					window_ring[i] = smp;
				ring_sum = total_t'(smp * WINDOW_LEN);
				oldest_slot = '0;
				ring_seeded = 1'b1;
			end else begin
				ring_sum = ring_sum - window_ring[oldest_slot] + smp;
				window_ring[oldest_slot] = smp;
				oldest_slot = oldest_slot + 1'b1;
			end
		end
		avg = ring_sum / WINDOW_LEN;
		lvl = (max_level * avg) / FULL_SCALE;
		if (lvl < min_level)
			lvl = min_level;
		expected_levels.push_back(level_t'(lvl));
	endtask

	task automatic queue_req(input logic act, input sample_t smp);
		light_req_t r;
		r.act = act;
		r.smp = smp;
		pending_reqs.push_back(r);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_MAX_BRIGHT)
			max_level = val;
		else if (idx == REG_MIN_BRIGHT)
			min_level = val;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_proc
		light_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_QUERY;
			light_sample <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				apply_light_request(action, light_sample);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					nxt = pending_reqs.pop_front();
					in_valid <= 1'b1;
					action <= nxt.act;
					light_sample <= nxt.smp;
					send_gap <= ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_proc
		level_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_levels.size() == 0) begin
					$error("brightness: no result expected, actual %0d", brightness);
					error_count++;
				end else begin
					want = expected_levels.pop_front();
					if (brightness !== want) begin
						$error("brightness: expected %0d, actual %0d", want, brightness);
						error_count++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 99) < stall_pct)
					hold_left <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("** ambient_light_brightness_average_core: FAILED **");
		$finish;
	end

	initial begin
		int n;
		int burst;
		sample_t smp;
		cfg_data_t mx;
		cfg_data_t mn;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Queries before any reading see an empty window, then the first push seeds it.
		queue_req(ACT_QUERY, 10'h000);
		queue_req(ACT_QUERY, 10'h3FF);
		queue_req(ACT_PUSH, 10'h3FF);
		queue_req(ACT_QUERY, 10'h000);
		queue_req(ACT_PUSH, 10'h000);
		queue_req(ACT_PUSH, 10'h000);
		queue_req(ACT_PUSH, 10'h155);
		queue_req(ACT_PUSH, 10'h2AA);
		queue_req(ACT_PUSH, 10'h001);
		queue_req(ACT_PUSH, 10'h3FF);
		queue_req(ACT_QUERY, 10'h155);
		queue_req(ACT_PUSH, 10'h200);
		queue_req(ACT_PUSH, 10'h3FE);
		for (int i = 0; i < 10; i++)
			queue_req(ACT_PUSH, 10'h000);
		queue_req(ACT_QUERY, 10'h2AA);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: begin mx = 8'd255; mn = 8'd0; end
				1: begin mx = 8'd0; mn = 8'd0; end
				2: begin mx = 8'd0; mn = 8'd255; end
				3: begin mx = 8'd128; mn = 8'd200; end
				4: begin mx = 8'd255; mn = 8'd255; end
				5: begin mx = 8'd1; mn = 8'd0; end
				default: begin
					mx = cfg_data_t'($urandom_range(0, 255));
					mn = cfg_data_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
						$urandom_range(0, 40));
				end
			endcase
			if ($urandom_range(0, 1)) begin
				write_reg(REG_MAX_BRIGHT, mx);
				write_reg(REG_MIN_BRIGHT, mn);
			end else begin
				write_reg(REG_MIN_BRIGHT, mn);
				write_reg(REG_MAX_BRIGHT, mx);
			end
			gap_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 50);
			stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(10, 50);
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 19) == 0) begin
					case ($urandom_range(0, 2))
						0: smp = 10'h000;
						1: smp = 10'h3FF;
						default: smp = sample_t'($urandom_range(0, 1023));
					endcase
					burst = $urandom_range(WINDOW_LEN, WINDOW_LEN + 4);
					for (int k = 0; k < burst; k++)
						queue_req(ACT_PUSH, smp);
					n += burst;
				end else begin
					case ($urandom_range(0, 7))
						0: smp = 10'h000;
						1: smp = 10'h3FF;
						default: smp = sample_t'($urandom_range(0, 1023));
					endcase
					queue_req(($urandom_range(0, 3) == 0) ? ACT_QUERY : ACT_PUSH, smp);
					n++;
				end
			end
		end
		wait_drained();

		if (error_count == 0)
			$display("** ambient_light_brightness_average_core: PASSED **");
		else
			$display("** ambient_light_brightness_average_core: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
